[rtl/tmq_pkg.sv]
// ----------------------------------------------------------------------------
// tmq_pkg: shared types and constants of the task multiplicity queue
// Request and response payloads, command and status codes, and the entry
// and chain records passed between the store cells.
// ----------------------------------------------------------------------------
package tmq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned TOTAL_W   = 12;
	localparam int unsigned TARGET_W  = 12;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_TRIM = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	// Operation broadcast to every cell in a cycle
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [ID_W-1:0]     task_id;
		logic [COUNT_W-1:0]  instances;
		logic                optional;
		logic [TARGET_W-1:0] target_size;
	} in_req_t;

	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     served_id;
		logic                served_optional;
		logic [TOTAL_W-1:0]  total_instances;
		logic                store_empty;
	} out_rsp_t;

	// One store slot
	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] count;
		logic               opt;
	} entry_t;

	// Carried front to back along the cell row
	typedef struct packed {
		logic            seen;  // a valid non-optional entry lies in front
		logic            rm;    // an entry in front is removed this cycle
		logic [ID_W-1:0] sid;   // id of the selected entry
		logic            sopt;  // optional mark of the selected entry
	} chain_t;

	// Store summary toward the control
	typedef struct packed {
		logic            empty;
		logic            full;
		logic            nxt_empty;
		logic [ID_W-1:0] served_id;
		logic            served_opt;
	} store_stat_t;

endpackage

[rtl/task_multiplicity_queue_top.sv]
// Push and pop responses are registered and appear in the cycle after acceptance.
// One push or pop per cycle while no trim runs and the response register drains.
// Trim pops until the total is below its target or the store is empty; the
// cell row serves one instance per cycle. Reset clears the slot valid bits, the
// instance total and the response register at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// task_multiplicity_queue_top: bounded task store with instance counts
// Accepts push, pop and trim requests, keeps the running instance total and
// drives a row of store cells; one response per request.
// ----------------------------------------------------------------------------
module task_multiplicity_queue_top import tmq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_rsp_t out_data
);

	typedef enum logic {
		S_IDLE,
		S_TRIM
	} state_t;

	state_t                state_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [TARGET_W-1:0]   target_q;
	logic                  out_valid_q;
	out_rsp_t              out_q;

	cell_op_t              op;
	entry_t                push_ent;
	store_stat_t           stat;
	logic                  out_free;
	logic                  acc;
	logic                  push_ok;
	logic [TOTAL_W:0]      push_sum;
	logic                  trim_more;

	tmq_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.push_ent (push_ent),
		.stat     (stat)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign acc      = in_valid && in_ready;

	assign push_sum  = {1'b0, total_q} + (TOTAL_W+1)'(in_data.instances);
	assign push_ok   = !stat.full && (in_data.instances != '0) &&
		(push_sum <= {1'b0, TOTAL_MAX});
	assign trim_more = (total_q >= target_q) && !stat.empty;

	assign push_ent.valid = 1'b1;
	assign push_ent.id    = in_data.task_id;
	assign push_ent.count = in_data.instances;
	assign push_ent.opt   = in_data.optional;

	// Store operation for this cycle
	always_comb begin
		op = OP_HOLD;
		if (state_q == S_TRIM) begin
			if (trim_more) begin
				op = OP_POP;
			end
		end else if (acc) begin
			unique case (in_data.cmd)
				CMD_PUSH: op = push_ok ? OP_PUSH : OP_HOLD;
				CMD_POP:  op = stat.empty ? OP_HOLD : OP_POP;
				default:  op = OP_HOLD;
			endcase
		end
	end

	// Control, instance total and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			target_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				OP_PUSH: total_q <= push_sum[TOTAL_W-1:0];
				OP_POP:  total_q <= (total_q != '0) ? total_q - TOTAL_W'(1) : total_q;
				default: total_q <= total_q;
			endcase
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						out_q.status          <= ST_OK;
						out_q.served_id       <= '0;
						out_q.served_optional <= 1'b0;
						out_q.store_empty     <= stat.nxt_empty;
						out_q.total_instances <= total_q;
						unique case (in_data.cmd)
							CMD_PUSH: begin
								out_valid_q <= 1'b1;
								if (push_ok) begin
									out_q.total_instances <= push_sum[TOTAL_W-1:0];
								end else begin
									out_q.status <= ST_REFUSED;
								end
							end
							CMD_POP: begin
								out_valid_q <= 1'b1;
								if (stat.empty) begin
									out_q.status <= ST_EMPTY;
								end else begin
									out_q.served_id       <= stat.served_id;
									out_q.served_optional <= stat.served_opt;
									out_q.total_instances <= total_q - TOTAL_W'(1);
								end
							end
							CMD_TRIM: begin
								target_q <= in_data.target_size;
								state_q  <= S_TRIM;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_TRIM: begin
					if (!trim_more && out_free) begin
						out_valid_q           <= 1'b1;
						out_q.status          <= ST_OK;
						out_q.served_id       <= '0;
						out_q.served_optional <= 1'b0;
						out_q.total_instances <= total_q;
						out_q.store_empty     <= stat.empty;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/tmq_cell.sv]
// ----------------------------------------------------------------------------
// tmq_cell: one slot of the task store
// Holds one entry; on push takes its front neighbor, on a pop removal
// at or in front of it takes its back neighbor, and decrements when it
// is the served entry.
// ----------------------------------------------------------------------------
module tmq_cell import tmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  logic     any_nonopt,
	input  entry_t   left,
	input  entry_t   right,
	input  chain_t   chain_in,
	output chain_t   chain_out,
	output entry_t   ent
);

	logic               valid_q;
	logic [ID_W-1:0]    id_q;
	logic [COUNT_W-1:0] count_q;
	logic               opt_q;
	entry_t             cur;
	entry_t             ent_d;
	logic               sel;
	logic               last_one;
	logic               take_right;

	assign cur = '{valid: valid_q, id: id_q, count: count_q, opt: opt_q};

	// Served entry: frontmost non-optional, else the back entry
	assign sel = cur.valid &&
		((!cur.opt && !chain_in.seen) || (!right.valid && !any_nonopt));
	assign last_one   = (cur.count == COUNT_W'(1));
	assign take_right = chain_in.rm || (sel && last_one);

	assign chain_out.seen = chain_in.seen || (cur.valid && !cur.opt);
	assign chain_out.rm   = (op == OP_POP) && take_right;
	assign chain_out.sid  = sel ? cur.id : chain_in.sid;
	assign chain_out.sopt = sel ? cur.opt : chain_in.sopt;

	// Next slot contents
	always_comb begin
		ent_d = cur;
		unique case (op)
			OP_PUSH: begin
				ent_d = left;
			end
			OP_POP: begin
				if (take_right) begin
					ent_d = right;
				end else if (sel) begin
					ent_d.count = cur.count - COUNT_W'(1);
				end
			end
			default: begin
				ent_d = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q    <= ent_d.id;
		count_q <= ent_d.count;
		opt_q   <= ent_d.opt;
	end

	assign ent = cur;

endmodule

[rtl/tmq_store.sv]
// ----------------------------------------------------------------------------
// tmq_store: row of store cells
// Slot 0 is the front. Entries stay packed; push shifts toward the back,
// removal shifts the entries behind the served one toward the front.
// ----------------------------------------------------------------------------
module tmq_store import tmq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_op_t        op,
	input  entry_t          push_ent,
	output store_stat_t     stat
);

	entry_t ent   [DEPTH];
	entry_t left  [DEPTH];
	entry_t right [DEPTH];
	chain_t chain [DEPTH+1];
	logic   any_nonopt;

	assign chain[0]   = '0;
	assign any_nonopt = chain[DEPTH].seen;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_front
			assign left[i] = push_ent;
		end else begin : g_mid
			assign left[i] = ent[i-1];
		end
		if (i == DEPTH-1) begin : g_back
			assign right[i] = '0;
		end else begin : g_inner
			assign right[i] = ent[i+1];
		end

		tmq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.any_nonopt (any_nonopt),
			.left       (left[i]),
			.right      (right[i]),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.ent        (ent[i])
		);
	end

	// Summary; a pop empties the store only when a single entry holds one instance
	always_comb begin
		stat.empty      = !ent[0].valid;
		stat.full       = ent[DEPTH-1].valid;
		stat.served_id  = chain[DEPTH].sid;
		stat.served_opt = chain[DEPTH].sopt;
		unique case (op)
			OP_PUSH: stat.nxt_empty = 1'b0;
			OP_POP:  stat.nxt_empty = !ent[1].valid &&
				(!ent[0].valid || (ent[0].count == COUNT_W'(1)));
			default: stat.nxt_empty = !ent[0].valid;
		endcase
	end

endmodule
